@@ rtl/core/grechk_pkg.sv @@
package grechk_pkg;

	localparam logic [1:0] ERR_OK       = 2'd0;
	localparam logic [1:0] ERR_SHORT    = 2'd1;
	localparam logic [1:0] ERR_RESERVED = 2'd2;
	localparam logic [1:0] ERR_CHECKSUM = 2'd3;

	localparam logic [3:0] HLEN_BASE = 4'd4;
	localparam logic [3:0] HLEN_CSUM = 4'd8;

	localparam int OUT_TDATA_W = 32;

	typedef struct packed {
		logic [3:0]  header_length;
		logic [15:0] protocol_type;
		logic [2:0]  gre_version;
		logic        checksum_present;
		logic [1:0]  error_code;
		logic        packet_ok;
	} result_t;

	function automatic logic [15:0] ones_add(input logic [15:0] a, input logic [15:0] b);
		logic [16:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[15:0] + {15'd0, s[16]};
	endfunction

endpackage

@@ rtl/core/grechk_acc.sv @@
module grechk_acc #(
	parameter int MAX_PACKET_BYTES = 65535
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                step,
	input  logic [7:0]          data_byte,
	input  logic                last_byte,
	output grechk_pkg::result_t res
);
	import grechk_pkg::*;

	localparam int CNT_W = $clog2(MAX_PACKET_BYTES + 1);
	localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_PACKET_BYTES);

	logic [CNT_W-1:0] byte_count_q;
	logic [15:0]      running_sum_q;
	logic [7:0]       high_byte_hold_q;
	logic [15:0]      first_word_q;
	logic [15:0]      protocol_word_q;
	logic [15:0]      stored_checksum_q;
	logic [15:0]      reserved_word_q;

	logic             taken;
	logic             odd_idx;
	logic             in_header;
	logic [7:0]       sum_byte;
	logic [15:0]      add_op;
	logic [15:0]      sum_add;
	logic [CNT_W-1:0] count_d;
	logic [15:0]      sum_d;
	logic [7:0]       hold_d;
	logic [15:0]      first_d;
	logic [15:0]      proto_d;
	logic [15:0]      csum_d;
	logic [15:0]      resv_d;
	logic [15:0]      final_sum;
	logic [15:0]      calc;
	logic             cbit;
	logic [3:0]       hlen;

	assign taken     = byte_count_q < CNT_MAX;
	assign odd_idx   = byte_count_q[0];
	assign in_header = byte_count_q < CNT_W'(8);
	// the checksum field itself counts as zero
	assign sum_byte  = (byte_count_q == CNT_W'(4) || byte_count_q == CNT_W'(5)) ?
			8'd0 : data_byte;

	// one adder serves both the pair sum and the pad of an odd final byte
	always_comb begin
		if (taken && odd_idx) begin
			add_op = {high_byte_hold_q, sum_byte};
		end else if (taken) begin
			add_op = {sum_byte, 8'd0};
		end else begin
			add_op = {high_byte_hold_q, 8'd0};
		end
	end

	assign sum_add = ones_add(running_sum_q, add_op);

	always_comb begin
		count_d = byte_count_q;
		sum_d   = running_sum_q;
		hold_d  = high_byte_hold_q;
		first_d = first_word_q;
		proto_d = protocol_word_q;
		csum_d  = stored_checksum_q;
		resv_d  = reserved_word_q;
		if (taken) begin
			count_d = byte_count_q + CNT_W'(1);
			if (odd_idx) begin
				sum_d = sum_add;
			end else begin
				hold_d = sum_byte;
			end
			if (in_header) begin
				case (byte_count_q[2:0])
					3'd0: first_d[15:8] = data_byte;
					3'd1: first_d[7:0]  = data_byte;
					3'd2: proto_d[15:8] = data_byte;
					3'd3: proto_d[7:0]  = data_byte;
					3'd4: csum_d[15:8]  = data_byte;
					3'd5: csum_d[7:0]   = data_byte;
					3'd6: resv_d[15:8]  = data_byte;
					default: resv_d[7:0] = data_byte;
				endcase
			end
		end
	end

	assign final_sum = count_d[0] ? sum_add : sum_d;
	assign calc      = (~final_sum == 16'd0) ? 16'hFFFF : ~final_sum;
	assign cbit      = first_d[15];
	assign hlen      = cbit ? HLEN_CSUM : HLEN_BASE;

	always_comb begin
		if (count_d < CNT_W'(hlen)) begin
			res.error_code = ERR_SHORT;
		end else if (first_d[14:3] != 12'd0 || (cbit && resv_d != 16'd0)) begin
			res.error_code = ERR_RESERVED;
		end else if (cbit && calc != csum_d) begin
			res.error_code = ERR_CHECKSUM;
		end else begin
			res.error_code = ERR_OK;
		end
		res.packet_ok        = res.error_code == ERR_OK;
		res.checksum_present = cbit;
		res.gre_version      = first_d[2:0];
		res.protocol_type    = proto_d;
		res.header_length    = hlen;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_count_q      <= '0;
			running_sum_q     <= '0;
			high_byte_hold_q  <= '0;
			first_word_q      <= '0;
			protocol_word_q   <= '0;
			stored_checksum_q <= '0;
			reserved_word_q   <= '0;
		end else if (step && last_byte) begin
			// clear for the next packet
			byte_count_q      <= '0;
			running_sum_q     <= '0;
			high_byte_hold_q  <= '0;
			first_word_q      <= '0;
			protocol_word_q   <= '0;
			stored_checksum_q <= '0;
			reserved_word_q   <= '0;
		end else if (step) begin
			byte_count_q      <= count_d;
			running_sum_q     <= sum_d;
			high_byte_hold_q  <= hold_d;
			first_word_q      <= first_d;
			protocol_word_q   <= proto_d;
			stored_checksum_q <= csum_d;
			reserved_word_q   <= resv_d;
		end
	end

endmodule

@@ rtl/core/grechk_out.sv @@
module grechk_out (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                load,
	input  grechk_pkg::result_t res,
	output logic                free,
	output logic                m_axis_tvalid,
	input  logic                m_axis_tready,
	output logic [grechk_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
	import grechk_pkg::*;

	logic    valid_q;
	result_t res_q;

	assign free = !valid_q || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res;
		end
	end

	assign m_axis_tvalid = valid_q;
	assign m_axis_tdata  = {(OUT_TDATA_W - $bits(result_t))'(0), res_q};

endmodule

@@ rtl/core/gre_header_checksum_validator_top.sv @@
// GRE header validator.
// Input: one packet byte per word on s_axis (tdata = data_byte), tlast on the
// final byte of the packet. Output: one verdict word on m_axis per packet,
// issued for the word that carried tlast; no output for other bytes.
// The block keeps a 16-bit ones' complement sum over byte pairs (checksum
// bytes 4 and 5 count as zero, an odd final byte is padded with zero) and
// captures header bytes 0..7. Verdict order: too short, reserved bits set,
// checksum mismatch. Bytes beyond MAX_PACKET_BYTES are dropped but tlast
// still closes the packet.
// Throughput: one byte per cycle while s_axis_tready is high, set by the
// single end-around add on the per-byte path. A verdict goes through the
// input register, then the result register, on its way to m_axis.
// Reset clears all packet state and empties both registers. When m_axis is
// stalled, the held verdict stays put; bytes of the next packet keep flowing
// until a second tlast byte would need the result register, then s_axis_tready
// drops until the verdict is taken.
module gre_header_checksum_validator_top #(
	parameter int MAX_PACKET_BYTES = 65535
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
	input  logic        s_axis_tlast,   // last_byte
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// [0] packet_ok, [2:1] error_code, [3] checksum_present, [6:4] gre_version,
	// [22:7] protocol_type, [26:23] header_length, [31:27] zero
	output logic [grechk_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
	import grechk_pkg::*;

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       last_s1;
	logic       out_free;
	logic       advance;
	result_t    res;

	// a non-final byte never needs the result register
	assign advance       = valid_s1 && (!last_s1 || out_free);
	assign s_axis_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			byte_s1 <= s_axis_tdata;
			last_s1 <= s_axis_tlast;
		end
	end

	grechk_acc #(
		.MAX_PACKET_BYTES(MAX_PACKET_BYTES)
	) u_acc (
		.clk      (clk),
		.arst_n   (arst_n),
		.step     (advance),
		.data_byte(byte_s1),
		.last_byte(last_s1),
		.res      (res)
	);

	grechk_out u_out (
		.clk          (clk),
		.arst_n       (arst_n),
		.load         (advance && last_s1),
		.res          (res),
		.free         (out_free),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata)
	);

endmodule

@@ tb/gre_header_checksum_validator_top_tb.sv @@
`timescale 1ns / 1ps

module gre_header_checksum_validator_top_tb;
	import grechk_pkg::*;

	localparam int          PKT_MAX     = 65535;
	localparam int unsigned CYCLE_LIMIT = 1000000;
	localparam int          PHASE_BYTES = 263;

	typedef enum {PK_GOOD, PK_BAD_SUM, PK_RESERVED, PK_SHORT, PK_NOISE} packet_kind_t;

	class gre_verdict_model;
		int unsigned byte_count;
		logic [15:0] pair_sum;
		logic [7:0]  pair_high;
		logic [7:0]  hdr [8];
		result_t     expected_verdicts[$];
		int          errors;

		// end-around add: a carry out of bit 15 comes back in at bit 0
		static function logic [15:0] fold16(input logic [15:0] a, input logic [15:0] b);
			int unsigned t;
			t = a + b;
			if (t > 32'h0000_FFFF)
				t = t - 32'h0000_FFFF;
			return t[15:0];
		endfunction

		function void clear();
			byte_count = 0;
			pair_sum = '0;
			pair_high = '0;
			foreach (hdr[i])
				hdr[i] = '0;
		endfunction

		function new();
			clear();
			errors = 0;
		endfunction

		function void take_byte(input logic [7:0] b, input bit last);
			logic [7:0]  summed;
			logic [15:0] first_w, resv_w, csum_w, s;
			bit          cbit;
			logic [3:0]  hlen;
			logic [1:0]  code;
			result_t     r;
			// drop bytes once the count has saturated
			if (byte_count < PKT_MAX) begin
				summed = (byte_count == 4 || byte_count == 5) ? 8'h00 : b;
				if (byte_count < 8)
					hdr[byte_count] = b;
				if (byte_count % 2 == 0)
					pair_high = summed;
				else
					pair_sum = fold16(pair_sum, {pair_high, summed});
				byte_count++;
			end
			if (!last)
				return;
			first_w = {hdr[0], hdr[1]};
			csum_w  = {hdr[4], hdr[5]};
			resv_w  = {hdr[6], hdr[7]};
			cbit    = first_w[15];
			hlen    = cbit ? HLEN_CSUM : HLEN_BASE;
			s = pair_sum;
			if (byte_count % 2 == 1)
				s = fold16(s, {pair_high, 8'h00});
			s = ~s;
			if (s == 16'h0000)
				s = 16'hFFFF;
			if (byte_count < hlen)
				code = ERR_SHORT;
			else if (first_w[14:3] != 12'h000 || (cbit && resv_w != 16'h0000))
				code = ERR_RESERVED;
			else if (cbit && s != csum_w)
				code = ERR_CHECKSUM;
			else
				code = ERR_OK;
			r.packet_ok        = (code == ERR_OK);
			r.error_code       = code;
			r.checksum_present = cbit;
			r.gre_version      = first_w[2:0];
			r.protocol_type    = {hdr[2], hdr[3]};
			r.header_length    = hlen;
			expected_verdicts.push_back(r);
			clear();
		endfunction

		function void compare(input string what, input int unsigned exp, input int unsigned got);
			if (exp != got) begin
				$display("%0t: %s expected %0h got %0h", $time, what, exp, got);
				errors++;
			end
		endfunction

		function void check_verdict(input logic [OUT_TDATA_W-1:0] word);
			result_t exp, got;
			if (expected_verdicts.size() == 0) begin
				$display("%0t: verdict word %h with none expected", $time, word);
				errors++;
				return;
			end
			exp = expected_verdicts.pop_front();
			got = word[26:0];
			compare("packet_ok", exp.packet_ok, got.packet_ok);
			compare("error_code", exp.error_code, got.error_code);
			compare("checksum_present", exp.checksum_present, got.checksum_present);
			compare("gre_version", exp.gre_version, got.gre_version);
			compare("protocol_type", exp.protocol_type, got.protocol_type);
			compare("header_length", exp.header_length, got.header_length);
			compare("pad bits", 0, word[OUT_TDATA_W-1:27]);
		endfunction

		function int pending();
			return expected_verdicts.size();
		endfunction
	endclass

	logic                   clk;
	logic                   arst_n = 1'b0;
	logic                   s_axis_tvalid = 1'b0;
	logic                   s_axis_tready;
	logic [7:0]             s_axis_tdata = 8'h00;
	logic                   s_axis_tlast = 1'b0;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;

	gre_verdict_model board = new();
	logic [7:0]       pkt_bytes[$];
	int               idle_pct = 0;
	int               stall_pct = 0;

	gre_header_checksum_validator_top #(
		.MAX_PACKET_BYTES(PKT_MAX)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tlast(s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic logic [15:0] packet_csum();
		int          n;
		logic [15:0] s;
		logic [7:0]  b, hi;
		n = (pkt_bytes.size() < PKT_MAX) ? pkt_bytes.size() : PKT_MAX;
		s = '0;
		hi = '0;
		for (int i = 0; i < n; i++) begin
			b = (i == 4 || i == 5) ? 8'h00 : pkt_bytes[i];
			if (i % 2 == 0)
				hi = b;
			else
				s = gre_verdict_model::fold16(s, {hi, b});
		end
		if (n % 2 == 1)
			s = gre_verdict_model::fold16(s, {hi, 8'h00});
		s = ~s;
		return (s == 16'h0000) ? 16'hFFFF : s;
	endfunction

	task automatic build_packet(input packet_kind_t kind, input int payload_len);
		bit          c;
		int          cut;
		logic [15:0] s;
		pkt_bytes.delete();
		if (kind == PK_NOISE) begin
			repeat ($urandom_range(1, 20))
				pkt_bytes.push_back(8'($urandom_range(255)));
			return;
		end
		c = (kind == PK_BAD_SUM) ? 1'b1 : 1'($urandom_range(1));
		pkt_bytes.push_back({c, 7'd0});
		pkt_bytes.push_back({5'd0, 3'($urandom_range(7))});
		pkt_bytes.push_back(8'($urandom_range(255)));
		pkt_bytes.push_back(8'($urandom_range(255)));
		if (c)
			repeat (4)
				pkt_bytes.push_back(8'h00);
		repeat (payload_len)
			pkt_bytes.push_back(8'($urandom_range(255)));
		if (c) begin
			s = packet_csum();
			pkt_bytes[4] = s[15:8];
			pkt_bytes[5] = s[7:0];
		end
		case (kind)
			PK_BAD_SUM: begin
				cut = $urandom_range(pkt_bytes.size() - 1);
				pkt_bytes[cut] = pkt_bytes[cut] ^ (8'h01 << $urandom_range(7));
			end
			PK_RESERVED: begin
				if (c && $urandom_range(1))
					pkt_bytes[6 + $urandom_range(1)] |= 8'h01 << $urandom_range(7);
				else if ($urandom_range(1))
					pkt_bytes[0] |= 8'h01 << $urandom_range(6);
				else
					pkt_bytes[1] |= 8'h08 << $urandom_range(4);
			end
			PK_SHORT: begin
				cut = $urandom_range(1, c ? 7 : 3);
				while (pkt_bytes.size() > cut)
					void'(pkt_bytes.pop_back());
			end
			default: ;
		endcase
	endtask

	task automatic send_byte(input logic [7:0] b, input bit last);
		while ($urandom_range(99) < idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= b;
		s_axis_tlast  <= last;
		do
			@(posedge clk);
		while (!s_axis_tready);
		board.take_byte(b, last);
	endtask

	task automatic send_packet();
		foreach (pkt_bytes[i])
			send_byte(pkt_bytes[i], i == pkt_bytes.size() - 1);
	endtask

	task automatic random_phase(input int idle, input int stall);
		int           sent;
		int           pick;
		packet_kind_t kind;
		idle_pct = idle;
		stall_pct = stall;
		sent = 0;
		while (sent < PHASE_BYTES) begin
			pick = $urandom_range(99);
			if (pick < 60)
				kind = PK_GOOD;
			else if (pick < 70)
				kind = PK_BAD_SUM;
			else if (pick < 80)
				kind = PK_RESERVED;
			else if (pick < 90)
				kind = PK_SHORT;
			else
				kind = PK_NOISE;
			build_packet(kind, ($urandom_range(9) == 0) ? $urandom_range(60) : $urandom_range(12));
			send_packet();
			sent += pkt_bytes.size();
		end
	endtask

	// accept and check verdict words; redraw the stall for the next cycle
	initial begin
		forever begin
			@(posedge clk);
			if (m_axis_tvalid && m_axis_tready)
				board.check_verdict(m_axis_tdata);
			m_axis_tready <= ($urandom_range(99) >= stall_pct);
		end
	end

	initial begin
		int unsigned cycles;
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles >= CYCLE_LIMIT) begin
				$display("FAIL gre_header_checksum_validator_top");
				$finish;
			end
		end
	end

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// single odd byte, too short
		pkt_bytes = '{8'hFF};
		send_packet();
		// minimal header without C bit, version 7
		pkt_bytes = '{8'h00, 8'h07, 8'hFF, 8'hFF};
		send_packet();
		// complemented sum of zero reads as 0xFFFF
		pkt_bytes = '{8'h80, 8'h00, 8'h7F, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00};
		send_packet();
		// C bit set but one byte short of the extended header
		pkt_bytes = '{8'h80, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
		send_packet();
		// all reserved0 bits set
		pkt_bytes = '{8'h7F, 8'hF8, 8'h00, 8'h00};
		send_packet();

		random_phase(0, 0);
		random_phase(65, 0);
		random_phase(0, 65);
		random_phase(7, 7);
		s_axis_tvalid <= 1'b0;

		while (board.pending() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (board.errors == 0)
			$display("PASS gre_header_checksum_validator_top");
		else
			$display("FAIL gre_header_checksum_validator_top");
		$finish;
	end

endmodule
